// File: rtl/core/pitb_pkg.sv
// Shared types and constants of the periodic interval timer bank.
package pitb_pkg;

  localparam int unsigned NumSlotsDef = 4;
  localparam int unsigned KindW       = 2;
  localparam int unsigned TimeW       = 48;
  localparam int unsigned PeriodW     = 24;
  localparam int unsigned TagW        = 16;
  localparam int unsigned SlotW       = 2;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [KindW-1:0] {
    KIND_TICK  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPT = 2'd0,
    ST_REFUSE = 2'd1,
    ST_FIRED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SET,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic take;
    logic scan;
    logic set;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic             in_valid;
    logic [KindW-1:0] in_kind;
    logic             scan_done;
    logic             due_any;
    logic             emit_last;
    logic             out_free;
  } sts_t;

endpackage

// File: rtl/core/pitb_if.sv
// Word channels of the timer bank: request and result interfaces.
interface pitb_in_if;
  logic                             valid;
  logic                             ready;
  logic [pitb_pkg::KindW-1:0]       kind;
  logic [pitb_pkg::TimeW-1:0]       now_ms;
  logic [pitb_pkg::PeriodW-1:0]     period;
  logic [pitb_pkg::TagW-1:0]        tag;
  logic [pitb_pkg::SlotW-1:0]       slot;

  modport source (output valid, kind, now_ms, period, tag, slot, input ready);
  modport sink (input valid, kind, now_ms, period, tag, slot, output ready);
endinterface

interface pitb_out_if;
  logic                             valid;
  logic                             ready;
  logic [pitb_pkg::StatusW-1:0]     status;
  logic [pitb_pkg::SlotW-1:0]       slot_index;
  logic [pitb_pkg::TagW-1:0]        fired_tag;
  logic                             last;

  modport source (output valid, status, slot_index, fired_tag, last, input ready);
  modport sink (input valid, status, slot_index, fired_tag, last, output ready);
endinterface

// File: rtl/core/pitb_ctrl.sv
// Controller state machine of the timer bank.
module pitb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pitb_pkg::sts_t  sts_i,
  output pitb_pkg::cmd_t  cmd_o
);

  pitb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pitb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      pitb_pkg::S_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.in_valid) begin
          unique case (sts_i.in_kind)
            pitb_pkg::KIND_TICK: state_d = pitb_pkg::S_SCAN;
            pitb_pkg::KIND_SET:  state_d = pitb_pkg::S_SET;
            default:             state_d = pitb_pkg::S_IDLE;
          endcase
        end
      end
      pitb_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.due_any ? pitb_pkg::S_EMIT : pitb_pkg::S_IDLE;
        end
      end
      pitb_pkg::S_SET: begin
        if (sts_i.out_free) begin
          cmd_o.set = 1'b1;
          state_d   = pitb_pkg::S_IDLE;
        end
      end
      pitb_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = pitb_pkg::S_IDLE;
          end
        end
      end
      default: state_d = pitb_pkg::S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/pitb_dp.sv
// Datapath of the timer bank: slot registers, scan counter, due mask, result register.
module pitb_dp #(
  parameter int unsigned NUM_SLOTS = pitb_pkg::NumSlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pitb_in_if.sink         in_i,
  pitb_out_if.source      out_o,
  input  pitb_pkg::cmd_t  cmd_i,
  output pitb_pkg::sts_t  sts_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0]              busy_q;
  logic [pitb_pkg::PeriodW-1:0]      period_q   [NUM_SLOTS];
  logic [pitb_pkg::TagW-1:0]         tag_q      [NUM_SLOTS];
  logic [pitb_pkg::TimeW-1:0]        deadline_q [NUM_SLOTS];

  logic [pitb_pkg::TimeW-1:0]        now_q;
  logic [pitb_pkg::PeriodW-1:0]      req_period_q;
  logic [pitb_pkg::TagW-1:0]         req_tag_q;
  logic [IdxW-1:0]                   cnt_q;
  logic [NUM_SLOTS-1:0]              mask_q;

  logic                              out_valid_q;
  logic [pitb_pkg::StatusW-1:0]      out_status_q;
  logic [pitb_pkg::SlotW-1:0]        out_idx_q;
  logic [pitb_pkg::TagW-1:0]         out_tag_q;
  logic                              out_last_q;

  logic                              accept;
  logic                              due_now;
  logic                              free_any;
  logic [IdxW-1:0]                   free_idx;
  logic [IdxW-1:0]                   emit_idx;
  logic [NUM_SLOTS-1:0]              mask_rest;
  logic                              out_ld;

  assign accept  = cmd_i.take && in_i.valid;
  assign in_i.ready = cmd_i.take;
  assign due_now = busy_q[cnt_q] && (deadline_q[cnt_q] <= now_q);
  assign out_ld  = cmd_i.set || cmd_i.emit;

  // lowest free slot and lowest due slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    emit_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
      if (mask_q[i]) begin
        emit_idx = IdxW'(i);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - NUM_SLOTS'(1));

  assign sts_o.in_valid  = in_i.valid;
  assign sts_o.in_kind   = in_i.kind;
  assign sts_o.scan_done = (cnt_q == IdxW'(NUM_SLOTS - 1));
  assign sts_o.due_any   = (|mask_q) || due_now;
  assign sts_o.emit_last = (mask_rest == '0);
  assign sts_o.out_free  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      mask_q      <= '0;
    end else begin
      if (accept) begin
        cnt_q  <= '0;
        mask_q <= '0;
        if ((in_i.kind == pitb_pkg::KIND_CLEAR) && (32'(in_i.slot) < NUM_SLOTS)) begin
          busy_q[IdxW'(in_i.slot)] <= 1'b0;
        end
      end
      if (cmd_i.scan) begin
        mask_q[cnt_q] <= due_now;
        cnt_q         <= cnt_q + IdxW'(1);
      end
      if (cmd_i.set && free_any) begin
        busy_q[free_idx] <= 1'b1;
      end
      if (cmd_i.emit) begin
        mask_q <= mask_rest;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q        <= in_i.now_ms;
      req_period_q <= in_i.period;
      req_tag_q    <= in_i.tag;
    end
    if (cmd_i.scan && due_now) begin
      deadline_q[cnt_q] <= deadline_q[cnt_q]
                           + pitb_pkg::TimeW'(period_q[cnt_q]);
    end
    if (cmd_i.set && free_any) begin
      period_q[free_idx]   <= req_period_q;
      tag_q[free_idx]      <= req_tag_q;
      deadline_q[free_idx] <= now_q + pitb_pkg::TimeW'(req_period_q);
    end
    if (cmd_i.set) begin
      out_status_q <= free_any ? pitb_pkg::ST_ACCEPT : pitb_pkg::ST_REFUSE;
      out_idx_q    <= free_any ? pitb_pkg::SlotW'(free_idx) : '0;
      out_tag_q    <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit) begin
      out_status_q <= pitb_pkg::ST_FIRED;
      out_idx_q    <= pitb_pkg::SlotW'(emit_idx);
      out_tag_q    <= tag_q[emit_idx];
      out_last_q   <= (mask_rest == '0);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot_index = out_idx_q;
  assign out_o.fired_tag  = out_tag_q;
  assign out_o.last       = out_last_q;

endmodule

// File: rtl/core/periodic_interval_timer_bank.sv
// Top level of the periodic interval timer bank.
// Usage:
//   in_i carries one request word: kind selects tick, set or clear. A set
//   claims the lowest free slot and answers with one word (accepted slot or
//   refusal). A clear frees a slot and answers nothing. A tick with the
//   current time yields one word per due slot, in slot order, last marked.
//   out_o carries result words from a single output register.
// Sequence:
//   clear: no result. set: the request is registered; the result word is
//   loaded in S_SET once the output register is free. tick: the request is
//   taken, all NUM_SLOTS slots are scanned (one deadline compare and update per
//   cycle), each fired word waits for a free output; no word when nothing is due.
//   Requests are taken one at a time, only while the controller is idle.
// Reset:
//   All slots free, controller idle, no result pending.
// Stall:
//   A stalled result word holds; the next set or fired word waits for the
//   output register to empty, and no new request is taken meanwhile.
module periodic_interval_timer_bank #(
  parameter int unsigned NUM_SLOTS = pitb_pkg::NumSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pitb_in_if.sink     in_i,
  pitb_out_if.source  out_o
);

  pitb_pkg::cmd_t cmd;
  pitb_pkg::sts_t sts;

  pitb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pitb_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
